// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define AST_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("port assertion failed");

// property checked on every clock edge, reset included
`define AST_ALL(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("reset assertion failed");

`endif

// ===== rtl/core/cvt_pkg.sv =====
// types, WGS-84 constants and fixed-point helpers for the ecef to geodetic converter
// no dependencies; constant tables are built at elaboration
package cvt_pkg;

  localparam int CORDIC_STEPS = 32;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int FIFO_DEPTH = 2;
  localparam int LEN_FRAC = 20;

  typedef logic signed [63:0] word_t;
  typedef logic [CORDIC_STEPS-1:0][63:0] ang_tab_t;

  typedef enum logic {CM_VEC, CM_ROT} cmode_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LON, S_P, S_PB, S_TH, S_SC1, S_C2, S_C3, S_S2, S_S3,
    S_NUM, S_DEN, S_LAT, S_SC2, S_PJ1, S_PJ2, S_U, S_V, S_R, S_RM,
    S_DLAT, S_DLON, S_OUT
  } bstate_t;

  typedef struct packed {
    logic  origin;
    word_t x;
    word_t y;
    word_t z;
  } item_t;

  typedef struct packed {
    logic   start;
    cmode_t mode;
    word_t  x;
    word_t  y;
    word_t  z;
  } cord_req_t;

  typedef struct packed {
    logic  done;
    word_t x;
    word_t y;
    word_t z;
  } cord_rsp_t;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic         neg;
    logic [127:0] mag;
  } mul_rsp_t;

  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SEMI_MAJOR_MM = 64'd6378137000;

  function automatic logic [63:0] umag(word_t v);
    return v[63] ? 64'(64'd0 - v) : 64'(v);
  endfunction

  function automatic word_t mq_sat(logic [127:0] mag, logic neg, int unsigned sh);
    logic [127:0] r;
    logic [63:0] m;
    r = mag >> sh;
    if (r > {64'd0, INT64_MAX}) m = INT64_MAX;
    else m = r[63:0];
    return neg ? word_t'(64'd0 - m) : word_t'(m);
  endfunction

  function automatic word_t mulq_c(word_t a, word_t b, int unsigned sh);
    logic [127:0] pr;
    pr = {64'd0, umag(a)} * {64'd0, umag(b)};
    return mq_sat(pr, a[63] ^ b[63], sh);
  endfunction

  function automatic logic [31:0] to_deg(logic [127:0] mag, logic neg, logic [31:0] lim);
    logic [38:0] q;
    q = ({1'b0, mag[127:90]} + 39'd1) >> 1;
    if (q > {7'd0, lim}) q = {7'd0, lim};
    return neg ? 32'(39'd0 - q) : q[31:0];
  endfunction

  // restoring long division, elaboration only
  function automatic logic [63:0] udiv(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    int k;
    rem = '0;
    q = '0;
    for (k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      q = q << 1;
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] udiv_shift(logic [63:0] num, int sh, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    logic b;
    int k;
    rem = '0;
    q = '0;
    for (k = 0; k < 64 + sh; k++) begin
      b = (k < 64) ? num[63-k] : 1'b0;
      rem = {rem[63:0], b};
      q = q << 1;
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atan_inv(logic [63:0] n);
    logic [63:0] t, sum, d;
    int k;
    t = udiv(64'd1 << 62, n);
    sum = t;
    if (n < (64'd1 << 31)) begin
      for (k = 1; k < 64; k++) begin
        if (t != 0) begin
          t = udiv(t, n * n);
          if (t != 0) begin
            d = udiv(t, 64'(2 * k + 1));
            if (k % 2 == 1) sum = sum - d;
            else sum = sum + d;
          end
        end
      end
    end
    return sum;
  endfunction

  function automatic ang_tab_t build_ang();
    ang_tab_t tab;
    logic [63:0] v;
    int i;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) v = atan_inv(64'd2) + atan_inv(64'd3);
      else v = atan_inv(64'd1 << i);
      tab[i] = (v + 64'd8) >> 4;
    end
    return tab;
  endfunction

  function automatic word_t calc_inv_gain();
    logic [63:0] k2;
    word_t y, t;
    int i;
    k2 = 64'd1 << 60;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      if (2 * i < 64) k2 = k2 + (k2 >> (2 * i));
    end
    y = word_t'(((64'd1 << 60) / 64'd5) * 64'd3);
    for (i = 0; i < 8; i++) begin
      t = mulq_c(y, y, 60);
      t = mulq_c(word_t'(k2), t, 60);
      y = mulq_c(y, word_t'(64'd3 << 60) - t, 61);
    end
    return y;
  endfunction

  localparam ang_tab_t ANG_TAB = build_ang();
  localparam word_t PI_Q58 = word_t'(ANG_TAB[0] << 2);
  localparam word_t HALF_PI_Q58 = word_t'(ANG_TAB[0] << 1);
  localparam word_t INV_GAIN = calc_inv_gain();
  localparam word_t DEG_SCALE = word_t'(udiv_shift(64'd1800000000, 91, PI_Q58));
  localparam word_t FLAT_Q62 = word_t'(udiv_shift(64'd1000000000, 62, 64'd298257223563));
  localparam word_t E2_Q62 = 2 * FLAT_Q62 - mulq_c(FLAT_Q62, FLAT_Q62, 62);
  localparam word_t A_LEN = word_t'(SEMI_MAJOR_MM << LEN_FRAC);
  localparam word_t B_LEN = A_LEN - mulq_c(A_LEN, FLAT_Q62, 62);
  localparam word_t A_E2_LEN = mulq_c(A_LEN, E2_Q62, 62);
  localparam word_t A_EP_LEN = mulq_c(A_LEN,
    word_t'(udiv_shift(E2_Q62, 62, (64'd1 << 62) - FLAT_Q62)), 62);

  localparam logic [31:0] LAT_LIM = 32'd900000000;
  localparam logic [31:0] LON_LIM = 32'd1800000000;
  localparam logic [36:0] ORIGIN_ALT = 37'(64'd0 - SEMI_MAJOR_MM);
  localparam logic [36:0] ALT_NEG_LIM = 37'h10_0000_0000;
  localparam logic [36:0] ALT_POS_LIM = 37'h0F_FFFF_FFFF;

endpackage

// ===== rtl/core/cvt_fifo.sv =====
// short queue of classified positions between front and back
// depends on cvt_pkg
module cvt_fifo import cvt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  nempty,
  output item_t pop_item
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign nempty = (cnt_r != '0);
  assign pop_item = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop) rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== rtl/core/cvt_front.sv =====
// input stage: takes positions, scales them to fixed point and flags the origin
// depends on cvt_pkg
module cvt_front import cvt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,
  output logic         push,
  output item_t        push_item,
  input  logic         q_full
);

  logic  valid_r;
  item_t item_r;
  logic [36:0] x, y, z;

  assign x = in_tdata[36:0];
  assign y = in_tdata[73:37];
  assign z = in_tdata[110:74];

  assign push = valid_r && !q_full;
  assign push_item = item_r;
  assign in_tready = !valid_r || !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (in_tready) valid_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.origin <= (x == '0) && (y == '0) && (z == '0);
      item_r.x <= {{7{x[36]}}, x, 20'd0};
      item_r.y <= {{7{y[36]}}, y, 20'd0};
      item_r.z <= {{7{z[36]}}, z, 20'd0};
    end
  end

endmodule

// ===== rtl/core/cvt_mul.sv =====
// 64x64 magnitude multiplier, one 32x32 partial product per cycle
// depends on cvt_pkg
module cvt_mul import cvt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [63:0] a_r, b_r;
  logic [127:0] acc_r;
  logic [1:0] k_r;
  logic busy_r, done_r, neg_r;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] pp_sh;

  assign pa = k_r[1] ? a_r[63:32] : a_r[31:0];
  assign pb = k_r[0] ? b_r[63:32] : b_r[31:0];
  assign pp = {32'd0, pa} * {32'd0, pb};

  always_comb begin
    case ({1'b0, k_r[1]} + {1'b0, k_r[0]})
      2'd0: pp_sh = {64'd0, pp};
      2'd1: pp_sh = {32'd0, pp, 32'd0};
      2'd2: pp_sh = {pp, 64'd0};
      default: pp_sh = '0;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.neg = neg_r;
  assign rsp.mag = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r <= '0;
    end else begin
      done_r <= busy_r && (k_r == 2'd3);
      if (req.start) begin
        busy_r <= 1'b1;
        k_r <= '0;
      end else if (busy_r) begin
        k_r <= k_r + 1'b1;
        if (k_r == 2'd3) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= umag(req.a);
      b_r <= umag(req.b);
      neg_r <= req.a[63] ^ req.b[63];
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

endmodule

// ===== rtl/core/cvt_cordic.sv =====
// shared iterative cordic: vectoring (atan2, magnitude) and rotation (sin, cos)
// depends on cvt_pkg
module cvt_cordic import cvt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cord_req_t req,
  output cord_rsp_t rsp
);

  localparam logic [STEP_W-1:0] LAST = STEP_W'(CORDIC_STEPS - 1);

  word_t x_r, y_r, z_r;
  logic [STEP_W-1:0] cnt_r;
  logic busy_r, done_r, zero_r;
  cmode_t mode_r;
  word_t dx, dy, ang;
  logic minus;

  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign ang = word_t'(ANG_TAB[cnt_r]);
  assign minus = (mode_r == CM_VEC) ? y_r[63] : !z_r[63];

  assign rsp.done = done_r;
  assign rsp.x = zero_r ? '0 : x_r;
  assign rsp.y = y_r;
  assign rsp.z = zero_r ? '0 : z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.mode;
      if (req.mode == CM_VEC) begin
        zero_r <= (req.x == '0) && (req.y == '0);
        if (req.x[63]) begin
          x_r <= -req.x;
          y_r <= -req.y;
          z_r <= req.y[63] ? -PI_Q58 : PI_Q58;
        end else begin
          x_r <= req.x;
          y_r <= req.y;
          z_r <= '0;
        end
      end else begin
        zero_r <= 1'b0;
        y_r <= '0;
        if (req.z > HALF_PI_Q58) begin
          x_r <= -INV_GAIN;
          z_r <= req.z - PI_Q58;
        end else if (req.z < -HALF_PI_Q58) begin
          x_r <= -INV_GAIN;
          z_r <= req.z + PI_Q58;
        end else begin
          x_r <= INV_GAIN;
          z_r <= req.z;
        end
      end
    end else if (busy_r) begin
      x_r <= minus ? x_r - dx : x_r + dx;
      y_r <= minus ? y_r + dy : y_r - dy;
      z_r <= minus ? z_r - ang : z_r + ang;
    end
  end

endmodule

// ===== rtl/core/cvt_back.sv =====
// back end: sequencer over the shared cordic and multiplier, output register
// depends on cvt_pkg, cvt_cordic, cvt_mul
module cvt_back import cvt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_nempty,
  input  item_t        q_item,
  output logic         q_pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [30:0]  out_lat,
  output logic [31:0]  out_lon,
  output logic [36:0]  out_alt
);

  bstate_t state_r, state_nxt;
  logic started_r, started_nxt;
  logic out_valid_r;
  logic origin_r;
  word_t xin_r, yin_r, zin_r, p_r, tmp_r, ct_r, st_r, c3_r, s3_r;
  word_t num_r, den_r, lon_a_r, lat_a_r, ang_r, proj_r;
  logic [30:0] lat_q_r, out_lat_r;
  logic [31:0] lon_q_r, out_lon_r;
  logic [36:0] out_alt_r, alt;
  cord_req_t creq;
  cord_rsp_t crsp;
  mul_req_t mreq;
  mul_rsp_t mrsp;
  word_t m60, m62;
  logic [63:0] habs, hsum;
  logic [43:0] hm;
  logic load_out;

  cvt_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));
  cvt_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  assign m60 = mq_sat(mrsp.mag, mrsp.neg, 60);
  assign m62 = mq_sat(mrsp.mag, mrsp.neg, 62);

  assign habs = umag(tmp_r);
  assign hsum = habs + (64'd1 << (LEN_FRAC - 1));
  assign hm = hsum[63:LEN_FRAC];

  always_comb begin
    if (origin_r) alt = ORIGIN_ALT;
    else if (tmp_r[63]) alt = (hm > {7'd0, ALT_NEG_LIM}) ? ALT_NEG_LIM : 37'(44'd0 - hm);
    else alt = (hm > {7'd0, ALT_POS_LIM}) ? ALT_POS_LIM : hm[36:0];
  end

  assign out_tvalid = out_valid_r;
  assign out_lat = out_lat_r;
  assign out_lon = out_lon_r;
  assign out_alt = out_alt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      started_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      started_r <= started_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop = 1'b0;
    load_out = 1'b0;
    creq = '{start: 1'b0, mode: CM_VEC, x: '0, y: '0, z: '0};
    mreq = '{start: 1'b0, a: '0, b: '0};
    case (state_r)
      S_IDLE: begin
        q_pop = q_nempty;
        if (q_nempty) state_nxt = q_item.origin ? S_OUT : S_LON;
      end
      S_LON: creq = '{start: !started_r, mode: CM_VEC, x: xin_r, y: yin_r, z: '0};
      S_TH:  creq = '{start: !started_r, mode: CM_VEC, x: tmp_r, y: zin_r, z: '0};
      S_SC1: creq = '{start: !started_r, mode: CM_ROT, x: '0, y: '0, z: ang_r};
      S_LAT: creq = '{start: !started_r, mode: CM_VEC, x: den_r, y: num_r, z: '0};
      S_SC2: creq = '{start: !started_r, mode: CM_ROT, x: '0, y: '0, z: lat_a_r};
      S_R:   creq = '{start: !started_r, mode: CM_VEC, x: num_r, y: den_r, z: '0};
      S_P:    mreq = '{start: !started_r, a: tmp_r, b: INV_GAIN};
      S_PB:   mreq = '{start: !started_r, a: p_r, b: FLAT_Q62};
      S_C2:   mreq = '{start: !started_r, a: ct_r, b: ct_r};
      S_C3:   mreq = '{start: !started_r, a: tmp_r, b: ct_r};
      S_S2:   mreq = '{start: !started_r, a: st_r, b: st_r};
      S_S3:   mreq = '{start: !started_r, a: tmp_r, b: st_r};
      S_NUM:  mreq = '{start: !started_r, a: A_EP_LEN, b: s3_r};
      S_DEN:  mreq = '{start: !started_r, a: A_E2_LEN, b: c3_r};
      S_PJ1:  mreq = '{start: !started_r, a: p_r, b: ct_r};
      S_PJ2:  mreq = '{start: !started_r, a: zin_r, b: st_r};
      S_U:    mreq = '{start: !started_r, a: A_LEN, b: ct_r};
      S_V:    mreq = '{start: !started_r, a: B_LEN, b: st_r};
      S_RM:   mreq = '{start: !started_r, a: tmp_r, b: INV_GAIN};
      S_DLAT: mreq = '{start: !started_r, a: lat_a_r, b: DEG_SCALE};
      S_DLON: mreq = '{start: !started_r, a: lon_a_r, b: DEG_SCALE};
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (crsp.done || mrsp.done) begin
      case (state_r)
        S_LON:  state_nxt = S_P;
        S_P:    state_nxt = S_PB;
        S_PB:   state_nxt = S_TH;
        S_TH:   state_nxt = S_SC1;
        S_SC1:  state_nxt = S_C2;
        S_C2:   state_nxt = S_C3;
        S_C3:   state_nxt = S_S2;
        S_S2:   state_nxt = S_S3;
        S_S3:   state_nxt = S_NUM;
        S_NUM:  state_nxt = S_DEN;
        S_DEN:  state_nxt = S_LAT;
        S_LAT:  state_nxt = S_SC2;
        S_SC2:  state_nxt = S_PJ1;
        S_PJ1:  state_nxt = S_PJ2;
        S_PJ2:  state_nxt = S_U;
        S_U:    state_nxt = S_V;
        S_V:    state_nxt = S_R;
        S_R:    state_nxt = S_RM;
        S_RM:   state_nxt = S_DLAT;
        S_DLAT: state_nxt = S_DLON;
        S_DLON: state_nxt = S_OUT;
        default: state_nxt = state_r;
      endcase
    end
    if (creq.start || mreq.start) started_nxt = 1'b1;
    else if (crsp.done || mrsp.done) started_nxt = 1'b0;
    else started_nxt = started_r;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      origin_r <= q_item.origin;
      xin_r <= q_item.x;
      yin_r <= q_item.y;
      zin_r <= q_item.z;
      lat_q_r <= '0;
      lon_q_r <= '0;
    end
    if (crsp.done || mrsp.done) begin
      case (state_r)
        S_LON: begin
          tmp_r <= crsp.x;
          lon_a_r <= crsp.z;
        end
        S_P:    p_r <= m60;
        S_PB:   tmp_r <= p_r - m62;
        S_TH:   ang_r <= crsp.z;
        S_SC1, S_SC2: begin
          ct_r <= crsp.x;
          st_r <= crsp.y;
        end
        S_C2, S_S2: tmp_r <= m60;
        S_C3:   c3_r <= m60;
        S_S3:   s3_r <= m60;
        S_NUM:  num_r <= zin_r + m60;
        S_DEN:  den_r <= p_r - m60;
        S_LAT:  lat_a_r <= crsp.z;
        S_PJ1:  proj_r <= m60;
        S_PJ2:  proj_r <= proj_r + m60;
        S_U:    num_r <= m60;
        S_V:    den_r <= m60;
        S_R:    tmp_r <= crsp.x;
        S_RM:   tmp_r <= proj_r - m60;
        S_DLAT: lat_q_r <= 31'(to_deg(mrsp.mag, mrsp.neg, LAT_LIM));
        S_DLON: lon_q_r <= to_deg(mrsp.mag, mrsp.neg, LON_LIM);
        default: ;
      endcase
    end
    if (load_out) begin
      out_lat_r <= lat_q_r;
      out_lon_r <= lon_q_r;
      out_alt_r <= alt;
    end
  end

endmodule

// ===== rtl/core/ecef_to_geodetic_converter.sv =====
// ecef to wgs-84 geodetic converter, bowring single-step latitude
// each position takes six passes through the shared cordic and fifteen multiplies in the
// back end, after the input stage register and the queue; the origin skips the cordic
// and multiplier and goes to the output state; the back end takes one position at a time
// and holds its result while out_tready is low; the queue takes new positions meanwhile
// synchronous active-low reset clears all handshake and sequencer state
module ecef_to_geodetic_converter import cvt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // ecef_x, ecef_y, ecef_z, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // latitude, longitude, altitude, zero pad
);

  logic push, q_full, q_nempty, q_pop;
  item_t push_item, q_item;
  logic [30:0] lat;
  logic [31:0] lon;
  logic [36:0] alt;

  cvt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .push(push), .push_item(push_item), .q_full(q_full)
  );

  cvt_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item), .full(q_full),
    .pop(q_pop), .nempty(q_nempty), .pop_item(q_item)
  );

  cvt_back u_back (
    .clk(clk), .rst_n(rst_n), .q_nempty(q_nempty), .q_item(q_item), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_lat(lat), .out_lon(lon), .out_alt(alt)
  );

  assign out_tdata = {4'd0, alt, lon, lat};

endmodule

// ===== rtl/core/cvt_checker.sv =====
// port-level checks for the ecef to geodetic converter, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module cvt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [111:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  `AST_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `AST_CLK(a_lat_range, out_tvalid |-> ($signed(out_tdata[30:0]) <= 31'sd900000000) && ($signed(out_tdata[30:0]) >= -31'sd900000000))
  `AST_CLK(a_lon_range, out_tvalid |-> ($signed(out_tdata[62:31]) <= 32'sd1800000000) && ($signed(out_tdata[62:31]) >= -32'sd1800000000))
  `AST_ALL(a_rst_quiet, !rst_n |=> !out_tvalid)

endmodule

bind ecef_to_geodetic_converter cvt_checker u_cvt_checker (.*);
